/* design/ccls_pkg.sv */
// ----------------------------------------------------------------------------
// ccls_pkg: shared definitions for the cyclic competition lattice step core
// Field widths, command and direction codes, register indexes, reset values
// and the cyclic dominance helper.
// ----------------------------------------------------------------------------
package ccls_pkg;

  localparam int COORD_W = 8;   // coordinate fields on the ports
  localparam int DIM_W   = 9;   // size registers and internal coordinates
  localparam int VAL_W   = 4;   // species code, 0 is empty
  localparam int THR_W   = 16;  // draw and thresholds, unsigned 0.16 fraction
  localparam int CMD_W   = 2;
  localparam int DIR_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_TYPES       = 3;
  localparam int MAX_DIM_DEFAULT = 256;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_THR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPRO_THR   = 2'd3;

  localparam logic [DIM_W-1:0] GRID_DIM_RESET   = 9'd256;
  localparam logic [THR_W-1:0] SELECT_THR_RESET = 16'd31969;
  localparam logic [THR_W-1:0] REPRO_THR_RESET  = 16'd63938;

  // Read and write strobes of the cell memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

  // Species that the given one beats: (v mod NUM_TYPES) + 1, by repeated
  // subtraction on the narrow value.
  function automatic logic [VAL_W-1:0] beat_target(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] m;
    m = v;
    for (int i = 0; i < 8; i++) begin
      if (m >= VAL_W'(NUM_TYPES)) begin
        m = m - VAL_W'(NUM_TYPES);
      end
    end
    return m + VAL_W'(1);
  endfunction

endpackage

/* design/cyclic_competition_lattice_step_core.sv */
// ----------------------------------------------------------------------------
// cyclic_competition_lattice_step_core: rock-paper-scissors lattice engine
// Keeps a toroidal grid of species cells and applies load, read and
// simulation step items, reporting every cell write as an update item.
// ----------------------------------------------------------------------------
// Usage. Items enter on the in_valid/in_ready channel: command, cell
// coordinates, neighbor direction, a 16-bit uniform draw and a load value.
// Results leave on the out_valid/out_ready channel, at most two per item, with
// last marking the final one. Size and threshold registers are written on
// the cfg_valid/cfg_ready channel, which is always ready.
// Flow: as the item is taken, both the cell and its neighbor are read from
// the cell memory; in the next cycle the result is decided, written back and
// placed in the output register. An exchange step writes two cells through
// the single write port, the cell in the decide state and the neighbor in the
// second-write state. Only one item is in work at a time, so the next item
// can never read a stale cell.
// Reset: the size and threshold registers return to their defaults and the
// memory is swept to empty, one cell per cycle, over all MAX_DIM*MAX_DIM cells
// (65536). in_ready stays low during the sweep.
// Stall: a result waits in the output register; the core holds in the
// decide or second-write cycle until the register can take a new result.
// ----------------------------------------------------------------------------
module cyclic_competition_lattice_step_core
  import ccls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // item input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [COORD_W-1:0]    pos_x,
  input  logic [COORD_W-1:0]    pos_y,
  input  logic [DIR_W-1:0]      direction,
  input  logic [THR_W-1:0]      action_draw,
  input  logic [VAL_W-1:0]      load_value,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_W-1:0]    out_x,
  output logic [COORD_W-1:0]    out_y,
  output logic [VAL_W-1:0]      out_value,
  output logic                  is_readback,
  output logic                  last,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MAX_DIM = MAX_DIM_DEFAULT;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_SWAP = 2'd2;

  // A size of zero acts as one, a size beyond the memory as the memory size.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [DIM_W-1:0] cx,
                                            input logic [DIM_W-1:0] cy);
    return AW'(32'(cy) * MAX_DIM + 32'(cx));
  endfunction

  // Configuration; the size registers hold the effective sizes.
  logic [DIM_W-1:0] width_eff, height_eff;
  logic [THR_W-1:0] select_thr, repro_thr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= eff_dim(GRID_DIM_RESET);
      height_eff <= eff_dim(GRID_DIM_RESET);
      select_thr <= SELECT_THR_RESET;
      repro_thr  <= REPRO_THR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  width_eff  <= eff_dim(cfg_data[DIM_W-1:0]);
        CFG_GRID_HEIGHT: height_eff <= eff_dim(cfg_data[DIM_W-1:0]);
        CFG_SELECT_THR:  select_thr <= cfg_data[THR_W-1:0];
        CFG_REPRO_THR:   repro_thr  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  logic [1:0] state, state_next;
  logic       mem_busy;
  logic       accept;

  assign in_ready = (state == ST_IDLE) && !mem_busy;
  assign accept   = in_valid && in_ready;

  // Neighbor coordinates of the incoming item, wrapping at the edges.
  logic [DIM_W-1:0] x_in, y_in, nx_in, ny_in;
  logic             inside_in;

  always_comb begin
    x_in      = DIM_W'(pos_x);
    y_in      = DIM_W'(pos_y);
    inside_in = (x_in < width_eff) && (y_in < height_eff);
    nx_in     = x_in;
    ny_in     = y_in;
    case (direction)
      DIR_LEFT:  nx_in = (x_in == '0) ? width_eff - DIM_W'(1) : x_in - DIM_W'(1);
      DIR_UP:    ny_in = (y_in == '0) ? height_eff - DIM_W'(1) : y_in - DIM_W'(1);
      DIR_RIGHT: nx_in = (x_in + DIM_W'(1) == width_eff) ? '0 : x_in + DIM_W'(1);
      DIR_DOWN:  ny_in = (y_in + DIM_W'(1) == height_eff) ? '0 : y_in + DIM_W'(1);
      default: ;
    endcase
  end

  // Item held while it is worked on.
  logic [CMD_W-1:0]   cmd_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [COORD_W-1:0] nx_q, ny_q;
  logic               inside_q;
  logic [THR_W-1:0]   draw_q;
  logic [VAL_W-1:0]   lv_q;
  logic [AW-1:0]      cell_addr_q, nbr_addr_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q       <= command;
      x_q         <= pos_x;
      y_q         <= pos_y;
      nx_q        <= nx_in[COORD_W-1:0];
      ny_q        <= ny_in[COORD_W-1:0];
      inside_q    <= inside_in;
      draw_q      <= action_draw;
      lv_q        <= load_value;
      cell_addr_q <= addr_of(x_in, y_in);
      nbr_addr_q  <= addr_of(nx_in, ny_in);
    end
  end

  // Cell memory: both reads are issued as the item is taken.
  mem_ctrl_t        mem_ctrl;
  logic [VAL_W-1:0] cv, nv;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_val;
  logic             wr_req, wr_nbr;

  ccls_cell_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mem_ctrl),
    .rd_addr_a (addr_of(x_in, y_in)),
    .rd_addr_b (addr_of(nx_in, ny_in)),
    .wr_addr   (wr_addr),
    .wr_data   (wr_val),
    .rd_data_a (cv),
    .rd_data_b (nv),
    .busy      (mem_busy)
  );

  // Decision on the read cells. cv stays valid through the second write of
  // an exchange because no read is issued until the next item.
  logic               emit, advance, to_swap;
  logic [COORD_W-1:0] res_x, res_y;
  logic [VAL_W-1:0]   res_v;
  logic               res_rb, res_last;
  logic               out_free;

  always_comb begin
    emit     = 1'b0;
    wr_req   = 1'b0;
    wr_nbr   = 1'b0;
    wr_val   = '0;
    to_swap  = 1'b0;
    res_x    = x_q;
    res_y    = y_q;
    res_v    = '0;
    res_rb   = 1'b0;
    res_last = 1'b1;
    if (state == ST_EVAL) begin
      case (cmd_q)
        CMD_LOAD: begin
          if (inside_q) begin
            emit   = 1'b1;
            wr_req = 1'b1;
            wr_val = lv_q;
            res_v  = lv_q;
          end
        end
        CMD_READ: begin
          emit   = 1'b1;
          res_rb = 1'b1;
          res_v  = inside_q ? cv : '0;
        end
        CMD_STEP: begin
          if (inside_q && cv != '0) begin
            if (draw_q < select_thr) begin
              // Selection: the neighbor dies if this cell beats it.
              if (nv != '0 && beat_target(cv) == nv) begin
                emit   = 1'b1;
                wr_req = 1'b1;
                wr_nbr = 1'b1;
                res_x  = nx_q;
                res_y  = ny_q;
              end
            end else if (draw_q < repro_thr) begin
              // Reproduction into an empty neighbor.
              if (nv == '0) begin
                emit   = 1'b1;
                wr_req = 1'b1;
                wr_nbr = 1'b1;
                wr_val = cv;
                res_x  = nx_q;
                res_y  = ny_q;
                res_v  = cv;
              end
            end else begin
              // Exchange: this cell first, the neighbor in the second-write state.
              emit     = 1'b1;
              wr_req   = 1'b1;
              wr_val   = nv;
              res_v    = nv;
              res_last = 1'b0;
              to_swap  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end else if (state == ST_SWAP) begin
      emit   = 1'b1;
      wr_req = 1'b1;
      wr_nbr = 1'b1;
      wr_val = cv;
      res_x  = nx_q;
      res_y  = ny_q;
      res_v  = cv;
    end
  end

  assign out_free       = !out_valid || out_ready;
  assign advance        = !emit || out_free;
  assign wr_addr        = wr_nbr ? nbr_addr_q : cell_addr_q;
  assign mem_ctrl.rd_en = accept;
  assign mem_ctrl.wr_en = wr_req && advance;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_EVAL;
      ST_EVAL: if (advance) state_next = to_swap ? ST_SWAP : ST_IDLE;
      ST_SWAP: if (advance) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && advance) begin
      out_x       <= res_x;
      out_y       <= res_y;
      out_value   <= res_v;
      is_readback <= res_rb;
      last        <= res_last;
    end
  end

endmodule

/* design/ccls_cell_mem.sv */
// ----------------------------------------------------------------------------
// ccls_cell_mem: lattice cell memory
// Two registered read ports and one write port. After reset a sweep writes
// every cell to empty, one cell per cycle, and busy stays high until done.
// ----------------------------------------------------------------------------
module ccls_cell_mem
  import ccls_pkg::*;
#(
  parameter int DEPTH = MAX_DIM_DEFAULT * MAX_DIM_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  mem_ctrl_t        ctrl,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  input  logic [AW-1:0]    wr_addr,
  input  logic [VAL_W-1:0] wr_data,
  output logic [VAL_W-1:0] rd_data_a,
  output logic [VAL_W-1:0] rd_data_b,
  output logic             busy
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [AW-1:0]    clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* design/ccls_checker.sv */
// ----------------------------------------------------------------------------
// ccls_port_checker: port-level checks for the lattice step core
// Watches the item and result channels and flags ordering slips.
// ----------------------------------------------------------------------------
module ccls_port_checker
  import ccls_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] out_x,
  input logic [COORD_W-1:0] out_y,
  input logic [VAL_W-1:0]   out_value,
  input logic               is_readback,
  input logic               last
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_value) && $stable(is_readback) && $stable(last))
    else $error("result changed while stalled");

  // A read answer is always the only result of its item.
  a_read_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_readback |-> last)
    else $error("read answer without last");

  // The second half of an exchange follows the first without a gap.
  a_swap_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && !is_readback)
    else $error("exchange pair broken");

  // One item at a time: no item is taken right after another.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");

endmodule

bind cyclic_competition_lattice_step_core ccls_port_checker u_ccls_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_x       (out_x),
  .out_y       (out_y),
  .out_value   (out_value),
  .is_readback (is_readback),
  .last        (last)
);
